>>> rtl/core/lkv_pkg.sv
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned CapW  = 5;

  localparam logic [CapW-1:0]  CapReset = 5'd16;
  // read data returned by a get that misses: all ones
  localparam logic [DataW-1:0] MissData = '1;

  typedef enum logic {
    ActGet = 1'b0,
    ActPut = 1'b1
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [KeyW-1:0]  lookup_key;
    logic [DataW-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [DataW-1:0] read_data;
  } rsp_t;

endpackage

>>> rtl/core/lkv_req_if.sv
`timescale 1ns / 1ps

interface lkv_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] lookup_key;
  logic signed [31:0] write_value;

  modport source (output valid, action, lookup_key, write_value, input ready);
  modport sink   (input valid, action, lookup_key, write_value, output ready);
endinterface

>>> rtl/core/lkv_rsp_if.sv
`timescale 1ns / 1ps

interface lkv_rsp_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] read_data;

  modport source (output valid, found, read_data, input ready);
  modport sink   (input valid, found, read_data, output ready);
endinterface

>>> rtl/core/lkv_store.sv
`timescale 1ns / 1ps

module lkv_store #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lkv_pkg::req_t         req_i,
  input  logic                  exec_i,
  input  logic [lkv_pkg::CapW-1:0] cap_i,
  output lkv_pkg::rsp_t         rsp_o
);
  import lkv_pkg::*;

  localparam int unsigned RankW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW  = (CntW > CapW) ? CntW : CapW;

  logic [KeyW-1:0]  key_q   [MAX_ENTRIES];
  logic [DataW-1:0] val_q   [MAX_ENTRIES];
  logic [RankW-1:0] rank_q  [MAX_ENTRIES];
  logic [RankW-1:0] rank_d  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [CntW-1:0]  occ_q, occ_d;

  logic [MAX_ENTRIES-1:0] hit_vec, free_vec, vic_vec, tgt_vec;
  logic             hit;
  logic [RankW-1:0] hit_rank;
  logic [DataW-1:0] hit_data;
  logic             free_seen;
  logic [CapW-1:0]  cap_eff;
  logic             insert_ok;
  logic [CntW-1:0]  thr;
  logic             is_put;
  logic             upd;

  assign is_put = (req_i.action == ActPut);

  // parallel tag compare; keys are unique among valid entries so hit_vec is one-hot
  always_comb begin
    hit_rank = '0;
    hit_data = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == req_i.lookup_key);
      vic_vec[i] = valid_q[i] && (CntW'(rank_q[i]) == (occ_q - CntW'(1)));
      if (hit_vec[i]) begin
        hit_rank = hit_rank | rank_q[i];
        hit_data = hit_data | val_q[i];
      end
    end
  end

  assign hit = |hit_vec;

  // lowest-numbered free slot
  always_comb begin
    free_seen = 1'b0;
    free_vec  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!valid_q[i] && !free_seen) begin
        free_vec[i] = 1'b1;
        free_seen   = 1'b1;
      end
    end
  end

  assign cap_eff   = (cap_i == '0) ? CapW'(1) : cap_i;
  assign insert_ok = (CmpW'(occ_q) < CmpW'(cap_eff)) && (occ_q < CntW'(MAX_ENTRIES));

  // Target slot and promotion threshold: valid entries ranked below thr age by one.
  // An insert uses thr = occupancy so that every valid entry ages.
  always_comb begin
    if (hit) begin
      tgt_vec = hit_vec;
      thr     = CntW'(hit_rank);
    end else if (insert_ok) begin
      tgt_vec = free_vec;
      thr     = occ_q;
    end else begin
      tgt_vec = vic_vec;
      thr     = occ_q - CntW'(1);
    end
  end

  assign upd = exec_i && (hit || is_put);

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (upd) begin
        if (tgt_vec[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (CntW'(rank_q[i]) < thr)) begin
          rank_d[i] = rank_q[i] + RankW'(1);
        end
      end
    end
    if (upd && !hit && insert_ok) begin
      valid_d = valid_q | free_vec;
      occ_d   = occ_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // key and value store, no reset: entries are only read once valid
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (upd && is_put && tgt_vec[i]) begin
        val_q[i] <= req_i.write_value;
        if (!hit) begin
          key_q[i] <= req_i.lookup_key;
        end
      end
    end
  end

  assign rsp_o.found     = hit;
  assign rsp_o.read_data = hit ? hit_data : MissData;

endmodule

>>> rtl/core/lru_key_value_cache.sv
`timescale 1ns / 1ps
// LRU key/value cache, fully associative, MAX_ENTRIES slots.
// req  (sink):   one beat per get (action 0) or put (action 1) with key and value.
// rsp  (source): one beat per get: found and read_data (all ones on a miss).
//                Puts produce no rsp beat.
// cfg:  cfg_we_i / cfg_wdata_i write the capacity register (0 acts as 1,
//       above MAX_ENTRIES acts as MAX_ENTRIES); write only while idle.
// Flow: a req beat is taken into the request register, then looked up and applied
//   to the store, and a get's result is written to the result register as it is applied.
// Throughput: one beat per cycle unless a stall holds a get; the whole lookup,
//   LRU rank update and victim choice run combinationally between the request
//   register and the store / result registers.
// Reset: all entries invalid, occupancy zero, capacity 16; no clearing pass.
// Stall: once the result register holds an unread beat and rsp is held off,
//   the next get waits in the request register and req.ready drops; puts
//   ahead of that get still complete since they give no rsp beat.
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  lkv_req_if.sink                  req,
  lkv_rsp_if.source                rsp,
  input  logic                     cfg_we_i,
  input  logic [lkv_pkg::CapW-1:0] cfg_wdata_i
);
  import lkv_pkg::*;

  logic            in_v_q;
  req_t            in_q;
  logic            out_v_q;
  rsp_t            out_q;
  logic [CapW-1:0] cap_q;
  rsp_t            lookup;
  logic            exec;
  logic            is_get;

  assign is_get = (in_q.action == ActGet);

  // a put always completes; a get needs room in the result register
  assign exec      = in_v_q && (!is_get || !out_v_q || rsp.ready);
  assign req.ready = !in_v_q || exec;

  lkv_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_lkv_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_q),
    .exec_i (exec),
    .cap_i  (cap_q),
    .rsp_o  (lookup)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      cap_q   <= CapReset;
    end else begin
      if (req.ready) begin
        in_v_q <= req.valid;
      end
      if (exec && is_get) begin
        out_v_q <= 1'b1;
      end else if (rsp.ready) begin
        out_v_q <= 1'b0;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      in_q.action      <= action_e'(req.action);
      in_q.lookup_key  <= req.lookup_key;
      in_q.write_value <= req.write_value;
    end
    if (exec && is_get) begin
      out_q <= lookup;
    end
  end

  assign rsp.valid     = out_v_q;
  assign rsp.found     = out_q.found;
  assign rsp.read_data = out_q.read_data;

endmodule

>>> rtl/core/lkv_checker.sv
`timescale 1ns / 1ps

module lkv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        rsp_found_i,
  input logic [31:0] rsp_data_i
);

  // a held rsp beat keeps its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_found_i) && $stable(rsp_data_i))
    else $error("rsp beat changed while stalled");

  a_miss_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_found_i |-> rsp_data_i == 32'hFFFF_FFFF)
    else $error("miss without all-ones data");

  // with the result register empty an offered req beat is never stalled
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !rsp_valid_i |-> req_ready_i)
    else $error("req stalled with empty result register");

  // nothing can be pending in the first cycle out of reset
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !rsp_valid_i)
    else $error("rsp beat straight out of reset");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .rsp_found_i (rsp.found),
  .rsp_data_i  (rsp.read_data)
);

>>> verif/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
  import lkv_pkg::*;

  localparam int unsigned Slots      = 16;
  localparam int unsigned LongHold   = 400;     // one long rsp back-pressure stretch
  localparam int unsigned DrainWait  = 4;       // lets puts still in the request register land
  localparam int unsigned PhaseItems = 62;
  localparam int unsigned PoolSize   = 32;
  localparam int unsigned ReportCap  = 200;     // keep the log short on a badly broken core
  localparam int          CycleLimit = 200000;

  // Shadow of the cache: tracks keys, values and recency ranks beat by beat
  // and queues the read beat that every get should produce.
  class lru_shadow;
    logic [KeyW-1:0]  keys   [Slots];
    logic [DataW-1:0] values [Slots];
    bit               live   [Slots];
    int unsigned      rank   [Slots];
    int unsigned      occupancy;
    logic [CapW-1:0]  capacity;
    rsp_t             pending_reads[$];
    int unsigned      failures;

    function new();
      for (int i = 0; i < Slots; i++) begin
        live[i] = 1'b0;
        rank[i] = 0;
      end
      occupancy = 0;
      capacity  = CapReset;
      failures  = 0;
    endfunction

    function void set_capacity(logic [CapW-1:0] v);
      capacity = v;
    endfunction

    function int unsigned outstanding();
      return pending_reads.size();
    endfunction

    // zero acts as one, anything above the slot count saturates
    function int unsigned live_limit();
      if (capacity == 0) return 1;
      if (capacity > Slots) return Slots;
      return capacity;
    endfunction

    function void make_newest(int unsigned s);
      int unsigned r;
      r = rank[s];
      for (int i = 0; i < Slots; i++)
        if (live[i] && rank[i] < r) rank[i]++;
      rank[s] = 0;
    endfunction

    function void apply_request(req_t r);
      int          hit;
      int          free_slot;
      int unsigned victim;
      int unsigned oldest;
      bit          any;
      hit = -1;
      for (int i = 0; i < Slots; i++)
        if (hit < 0 && live[i] && keys[i] == r.lookup_key) hit = i;

      if (r.action == ActGet) begin
        if (hit >= 0) begin
          make_newest(hit);
          pending_reads.push_back(rsp_t'{found: 1'b1, read_data: values[hit]});
        end else begin
          pending_reads.push_back(rsp_t'{found: 1'b0, read_data: MissData});
        end
        return;
      end

      if (hit >= 0) begin
        make_newest(hit);
        values[hit] = r.write_value;
        return;
      end

      if (occupancy < live_limit()) begin
        free_slot = -1;
        for (int i = 0; i < Slots; i++)
          if (free_slot < 0 && !live[i]) free_slot = i;
        if (free_slot >= 0) begin
          for (int i = 0; i < Slots; i++)
            if (live[i]) rank[i]++;
          live[free_slot]   = 1'b1;
          keys[free_slot]   = r.lookup_key;
          values[free_slot] = r.write_value;
          rank[free_slot]   = 0;
          occupancy++;
          return;
        end
      end

      // full (or capacity lowered under occupancy): overwrite the oldest entry
      victim = 0;
      oldest = 0;
      any    = 1'b0;
      for (int i = 0; i < Slots; i++) begin
        if (live[i] && (!any || rank[i] >= oldest)) begin
          oldest = rank[i];
          victim = i;
          any    = 1'b1;
        end
      end
      if (any) begin
        keys[victim]   = r.lookup_key;
        values[victim] = r.write_value;
        make_newest(victim);
      end
    endfunction

    function void check_read(logic found, logic [DataW-1:0] data);
      rsp_t exp;
      if (pending_reads.size() == 0) begin
        failures++;
        if (failures <= ReportCap)
          $error("read beat with nothing expected: found %0b read_data %h", found, data);
        return;
      end
      exp = pending_reads.pop_front();
      if (found !== exp.found) begin
        failures++;
        if (failures <= ReportCap)
          $error("found: expected %0b, actual %0b", exp.found, found);
      end
      if (data !== exp.read_data) begin
        failures++;
        if (failures <= ReportCap)
          $error("read_data: expected %h, actual %h", exp.read_data, data);
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CapW-1:0] cfg_wdata_i;

  lkv_req_if req_ch ();
  lkv_rsp_if rsp_ch ();

  lru_key_value_cache #(
    .MAX_ENTRIES (Slots)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  lru_shadow sb;

  // Shared between the stimulus and the rsp-side process.
  bit          calm;          // no idling on either side in the closing phase
  bit          hold_request;  // ask the rsp side for one long stall
  int          tx_window;
  bit          tx_gaps;
  int          rx_window;
  bit          rx_stalls;
  int          stall_left;
  int          cycle_count;
  logic [KeyW-1:0] key_pool [PoolSize];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a run that reaches CycleLimit is ended as a failure.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Monitor: both channels are sampled at the edge, before any of this
  // edge's nonblocking updates land, so the view is race free. Requests are
  // noted before reads are checked; a get's beat can only come out later.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready)
        sb.apply_request(req_t'{action:      action_e'(req_ch.action),
                                lookup_key:  req_ch.lookup_key,
                                write_value: req_ch.write_value});
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_read(rsp_ch.found, rsp_ch.read_data);
    end
  end

  // Read side: short stall bursts inside windows that are randomly noisy or
  // clean, plus one long hold-off on request so that gets back up and
  // req.ready drops while puts ahead of the waiting get keep going.
  initial begin
    rsp_ch.ready <= 1'b0;
    stall_left = 0;
    rx_window  = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LongHold - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (rx_window == 0) begin
          rx_window = $urandom_range(20, 80);
          rx_stalls = ($urandom_range(0, 2) != 0);
        end
        rx_window--;
        if (!calm && rx_stalls && $urandom_range(0, 3) == 0) begin
          stall_left = $urandom_range(0, 4);
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Offer one request beat and return at the edge that takes it. valid is
  // left high so back-to-back beats need no second assignment in a step.
  task automatic send_req(action_e act, logic [KeyW-1:0] key, logic [DataW-1:0] value);
    if (tx_window == 0) begin
      tx_window = $urandom_range(20, 80);
      tx_gaps   = ($urandom_range(0, 2) != 0);
    end
    tx_window--;
    if (!calm && tx_gaps && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.action      <= act;
    req_ch.lookup_key  <= key;
    req_ch.write_value <= value;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Let everything in flight come out, then give puts time to land.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Capacity is only touched with the core idle.
  task automatic write_capacity(logic [CapW-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_capacity(v);
  endtask

  // Random request: mostly keys from a pool sized a little past the live
  // limit (hits, updates and evictions), now and then a fresh 32-bit key.
  task automatic random_req(int unsigned span);
    action_e         act;
    logic [KeyW-1:0] key;
    logic [DataW-1:0] value;
    act   = ($urandom_range(0, 1) == 1) ? ActPut : ActGet;
    key   = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, span - 1)] : $urandom();
    case ($urandom_range(0, 15))
      0:       value = '0;
      1:       value = '1;
      default: value = $urandom();
    endcase
    send_req(act, key, value);
  endtask

  initial begin
    logic [CapW-1:0] phase_caps [10];
    int unsigned     span;
    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd16, 5'd3, 5'd8, 5'd16};

    sb = new();
    calm         = 1'b0;
    hold_request = 1'b0;
    tx_window    = 0;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.action      <= ActGet;
    req_ch.lookup_key  <= '0;
    req_ch.write_value <= '0;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    for (int i = 4; i < PoolSize; i++) key_pool[i] = $urandom();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty lookup, extreme keys and values, put over an existing
    // key, then capacity cut below occupancy, zero and saturated capacity.
    send_req(ActGet, 32'h0000_0000, 32'h0000_0000);
    send_req(ActPut, 32'h8000_0000, 32'h7fff_ffff);
    send_req(ActPut, 32'h7fff_ffff, 32'h8000_0000);
    send_req(ActPut, 32'h0000_0000, 32'h0000_0000);
    send_req(ActPut, 32'hffff_ffff, 32'hffff_ffff);
    send_req(ActGet, 32'h8000_0000, 32'h0000_0000);
    send_req(ActGet, 32'hffff_ffff, 32'h0000_0000);   // hit whose data equals the miss pattern
    send_req(ActPut, 32'h0000_0000, 32'h1234_5678);
    send_req(ActGet, 32'h0000_0000, 32'hffff_ffff);
    send_req(ActGet, 32'h5555_5555, 32'h0000_0000);
    send_req(ActGet, 32'haaaa_aaaa, 32'h0000_0000);

    // four entries held, limit now two: misses replace the oldest in place
    write_capacity(5'd2);
    send_req(ActPut, 32'haaaa_aaaa, 32'h5555_5555);
    send_req(ActGet, 32'h7fff_ffff, 32'h0000_0000);
    send_req(ActPut, 32'h5555_5555, 32'haaaa_aaaa);
    send_req(ActGet, 32'haaaa_aaaa, 32'h0000_0000);
    send_req(ActGet, 32'h0000_0000, 32'h0000_0000);

    write_capacity(5'd0);
    send_req(ActPut, 32'h0000_0001, 32'h0000_0002);
    send_req(ActPut, 32'h0000_0003, 32'h0000_0004);
    send_req(ActGet, 32'h0000_0001, 32'h0000_0000);
    send_req(ActGet, 32'h0000_0003, 32'h0000_0000);

    write_capacity(5'd31);
    send_req(ActPut, 32'h0000_0006, 32'h0000_0007);
    send_req(ActGet, 32'h0000_0006, 32'h0000_0000);
    send_req(ActGet, 32'h0000_0003, 32'h0000_0000);
    send_req(ActPut, 32'h0000_0003, 32'h0000_0005);
    send_req(ActGet, 32'h0000_0003, 32'h0000_0000);

    // Random phases, each under its own capacity. The seventh
    // phase carries the long read-side hold-off; the last one runs clean.
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      if (p == 6) hold_request = 1'b1;
      if (p == 9) calm = 1'b1;
      span = sb.live_limit() + 4;
      if (span > PoolSize) span = PoolSize;
      repeat (PhaseItems) random_req(span);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
